>>> sv/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants for the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

  // free-running capture counter width (range 16..32)
  localparam int CNT_W   = 24;
  localparam int PULSE_W = 24;
  localparam int DIST_W  = 23;
  localparam int PT_W    = 16;
  localparam int TMO_W   = 24;
  localparam int WRAP_W  = 32;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 2;

  // round(17.15 * 256 * 65536 / 16000)
  localparam int MUL_W  = 15;
  localparam int PROD_W = CNT_W + MUL_W;
  localparam int FULL_W = PROD_W - 16;
  localparam int SAT_W  = (FULL_W > DIST_W) ? FULL_W : DIST_W;
  localparam logic [MUL_W-1:0]  DIST_MUL = 15'd17983;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [PT_W-1:0]  PRE_LOW_RST  = 16'd32;
  localparam logic [PT_W-1:0]  TRIG_HI_RST  = 16'd80;
  localparam logic [TMO_W-1:0] TIMEOUT_RST  = 24'd800000;

  typedef enum logic [IDX_W-1:0] {
    REG_PRE_LOW = 2'd0,
    REG_TRIG_HI = 2'd1,
    REG_TIMEOUT = 2'd2
  } reg_idx_t;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_PRE_LOW   = 5'b00010,
    PH_HIGH      = 5'b00100,
    PH_WAIT_RISE = 5'b01000,
    PH_WAIT_FALL = 5'b10000
  } phase_t;

  typedef struct packed {
    logic kind;
    logic echo_level;
  } in_t;

  typedef struct packed {
    logic               trigger_level;
    logic               busy_res;
    logic               result_valid;
    logic               timed_out;
    logic [PULSE_W-1:0] pulse_ticks;
    logic               wrapped;
    logic [DIST_W-1:0]  distance_q8;
    logic [WRAP_W-1:0]  wrap_total;
  } out_t;

endpackage

`default_nettype wire

>>> sv/ultrasonic_echo_ranger_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// Ping-sensor pulse-width ranging: trigger pulse, echo capture, distance.
// ----------------------------------------------------------------------------
// Each input transfer is one sensor clock tick (kind = start request, plus the
// sampled echo pin); each one produces exactly one result transfer. The block
// takes one tick per cycle unless a held result stalls it: the full per-tick
// update of the trigger sequencer, edge captures and timeout runs in a single
// pass into the state registers and a result register, and the only arithmetic
// after that register is the distance multiply on the stored echo width. A
// held result does not stall input while out_ready is high in the same cycle.
// Configuration (pre-low, trigger-high, timeout tick counts) is written through
// cfg_we/cfg_idx/cfg_wdata while no measurement traffic is pending.
`default_nettype none

module ultrasonic_echo_ranger_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [uer_pkg::IDX_W-1:0]   cfg_idx,
  input  wire logic [uer_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire uer_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output uer_pkg::out_t                    out_data
);

  // configuration
  logic [uer_pkg::PT_W-1:0]  pre_low_ticks;
  logic [uer_pkg::PT_W-1:0]  trigger_high_ticks;
  logic [uer_pkg::TMO_W-1:0] timeout_ticks;

  // state
  uer_pkg::phase_t             phase, phase_next;
  logic [uer_pkg::CNT_W-1:0]   down_counter;
  logic [uer_pkg::PT_W-1:0]    phase_ticks, phase_ticks_next;
  logic [uer_pkg::TMO_W-1:0]   elapsed_ticks, elapsed_ticks_next;
  logic [uer_pkg::CNT_W-1:0]   rise_capture, rise_capture_next;
  logic                        prev_echo;
  logic [uer_pkg::CNT_W-1:0]   last_width, last_width_next;
  logic                        last_wrapped, last_wrapped_next;
  logic [uer_pkg::WRAP_W-1:0]  wrap_count, wrap_count_next;

  // result register
  logic r_trig, r_busy, r_valid, r_tmo;
  logic trig_next, valid_next, tmo_next;

  logic accept;
  logic start, echo, rise, fall;
  uer_pkg::phase_t           ph_a, ph_b, ph_c;
  logic [uer_pkg::PT_W-1:0]  pt_a, pt_b;
  logic [uer_pkg::DIST_W-1:0] dist_q8;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign start    = in_data.kind;
  assign echo     = in_data.echo_level;
  assign rise     = echo && !prev_echo;
  assign fall     = !echo && prev_echo;

  always_comb begin
    ph_a               = phase;
    pt_a               = phase_ticks;
    elapsed_ticks_next = elapsed_ticks;
    last_width_next    = last_width;
    last_wrapped_next  = last_wrapped;
    rise_capture_next  = rise_capture;
    wrap_count_next    = wrap_count;
    valid_next         = 1'b0;
    tmo_next           = 1'b0;

    if (start) begin
      ph_a               = uer_pkg::PH_PRE_LOW;
      pt_a               = '0;
      elapsed_ticks_next = '0;
      last_width_next    = '0;
      last_wrapped_next  = 1'b0;
    end

    // trigger sequencer: zero-length phases fall through on the same tick
    ph_b = ph_a;
    pt_b = pt_a;
    if (ph_a == uer_pkg::PH_PRE_LOW && pt_a >= pre_low_ticks) begin
      ph_b = uer_pkg::PH_HIGH;
      pt_b = '0;
    end
    ph_c             = ph_b;
    phase_ticks_next = pt_b;
    if (ph_b == uer_pkg::PH_HIGH && pt_b >= trigger_high_ticks) begin
      ph_c             = uer_pkg::PH_WAIT_RISE;
      phase_ticks_next = '0;
    end
    trig_next = (ph_c == uer_pkg::PH_HIGH);
    if (ph_c == uer_pkg::PH_PRE_LOW || ph_c == uer_pkg::PH_HIGH) begin
      phase_ticks_next = phase_ticks_next + 1'b1;
    end

    phase_next = ph_c;
    if (ph_c != uer_pkg::PH_IDLE) begin
      elapsed_ticks_next = elapsed_ticks_next + 1'b1;
      if (ph_c == uer_pkg::PH_WAIT_RISE && rise) begin
        rise_capture_next = down_counter;
        phase_next        = uer_pkg::PH_WAIT_FALL;
      end else if (ph_c == uer_pkg::PH_WAIT_FALL && fall) begin
        last_width_next = rise_capture - down_counter;
        if (rise_capture < down_counter) begin
          last_wrapped_next = 1'b1;
          wrap_count_next   = wrap_count + 1'b1;
        end else begin
          last_wrapped_next = 1'b0;
        end
        phase_next = uer_pkg::PH_IDLE;
        valid_next = 1'b1;
      end
      if (phase_next != uer_pkg::PH_IDLE && elapsed_ticks_next >= timeout_ticks) begin
        last_width_next = '0;
        phase_next      = uer_pkg::PH_IDLE;
        valid_next      = 1'b1;
        tmo_next        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_low_ticks      <= uer_pkg::PRE_LOW_RST;
      trigger_high_ticks <= uer_pkg::TRIG_HI_RST;
      timeout_ticks      <= uer_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        uer_pkg::REG_PRE_LOW: pre_low_ticks      <= cfg_wdata[uer_pkg::PT_W-1:0];
        uer_pkg::REG_TRIG_HI: trigger_high_ticks <= cfg_wdata[uer_pkg::PT_W-1:0];
        uer_pkg::REG_TIMEOUT: timeout_ticks      <= cfg_wdata[uer_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= uer_pkg::PH_IDLE;
      down_counter  <= '1;
      phase_ticks   <= '0;
      elapsed_ticks <= '0;
      rise_capture  <= '0;
      prev_echo     <= 1'b0;
      last_width    <= '0;
      last_wrapped  <= 1'b0;
      wrap_count    <= '0;
      out_valid     <= 1'b0;
      r_trig        <= 1'b0;
      r_busy        <= 1'b0;
      r_valid       <= 1'b0;
      r_tmo         <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      down_counter  <= down_counter - 1'b1;
      phase_ticks   <= phase_ticks_next;
      elapsed_ticks <= elapsed_ticks_next;
      rise_capture  <= rise_capture_next;
      prev_echo     <= echo;
      last_width    <= last_width_next;
      last_wrapped  <= last_wrapped_next;
      wrap_count    <= wrap_count_next;
      out_valid     <= 1'b1;
      r_trig        <= trig_next;
      r_busy        <= (phase_next != uer_pkg::PH_IDLE);
      r_valid       <= valid_next;
      r_tmo         <= tmo_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // width, wrap flag and wrap count only change on accept, so they track the
  // result register
  uer_dist u_dist (
    .ticks   (last_width),
    .dist_q8 (dist_q8)
  );

  always_comb begin
    out_data.trigger_level = r_trig;
    out_data.busy_res      = r_busy;
    out_data.result_valid  = r_valid;
    out_data.timed_out     = r_tmo;
    out_data.pulse_ticks   = uer_pkg::PULSE_W'(last_width);
    out_data.wrapped       = last_wrapped;
    out_data.distance_q8   = dist_q8;
    out_data.wrap_total    = wrap_count;
  end

endmodule

`default_nettype wire

>>> sv/uer_dist.sv
// ----------------------------------------------------------------------------
// uer_dist
// Echo width to distance in 1/256 cm: (ticks * 17983) >> 16, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_dist (
  input  wire logic [uer_pkg::CNT_W-1:0]  ticks,
  output logic      [uer_pkg::DIST_W-1:0] dist_q8
);

  logic [uer_pkg::PROD_W-1:0] prod;
  logic [uer_pkg::SAT_W-1:0]  full;

  assign prod = uer_pkg::PROD_W'(ticks) * uer_pkg::PROD_W'(uer_pkg::DIST_MUL);
  assign full = uer_pkg::SAT_W'(prod[uer_pkg::PROD_W-1:16]);

  always_comb begin
    if (full > uer_pkg::SAT_W'(uer_pkg::DIST_MAX)) begin
      dist_q8 = uer_pkg::DIST_MAX;
    end else begin
      dist_q8 = full[uer_pkg::DIST_W-1:0];
    end
  end

endmodule

`default_nettype wire
